>>> rtl/top_k_latest_by_timestamp_top_defines.svh
// assertion macros for the latest-k record keeper
`ifndef TOP_K_LATEST_BY_TIMESTAMP_TOP_DEFINES_SVH
`define TOP_K_LATEST_BY_TIMESTAMP_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define TKL_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("tkl check failed");

// next-cycle implication, off during reset
`define TKL_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("tkl check failed");

// next-cycle implication that also holds across reset
`define TKL_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("tkl check failed");

`endif

>>> rtl/tkl_pkg.sv
package tkl_pkg;

  localparam int CFG_W     = 7;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_KEEP_COUNT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_BATCH_SIZE = 1'b1;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  localparam logic [CFG_W-1:0] KEEP_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0] BATCH_SIZE_RST = 7'd64;

  typedef struct packed {
    logic               mode;
    logic signed [63:0] stamp;
    logic [31:0]        record_handle;
  } tkl_in_t;

  typedef struct packed {
    logic signed [63:0] out_stamp;
    logic [31:0]        out_handle;
    logic               batch_end;
    logic               last;
  } tkl_out_t;

  typedef struct packed {
    logic signed [63:0] stamp;
    logic [31:0]        handle;
  } tkl_entry_t;

  typedef struct packed {
    logic lt_key;
    logic lt_full;
  } tkl_cmp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } tkl_state_t;

endpackage

>>> rtl/tkl_mem.sv
module tkl_mem
  import tkl_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  tkl_entry_t    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output tkl_entry_t    rd_data
);

  tkl_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/tkl_cmp.sv
module tkl_cmp
  import tkl_pkg::*;
(
  input  tkl_entry_t a,
  input  tkl_entry_t b,
  output tkl_cmp_t   res
);

  logic key_lt;
  logic key_eq;

  assign key_lt      = $signed(a.stamp) < $signed(b.stamp);
  assign key_eq      = a.stamp == b.stamp;
  assign res.lt_key  = key_lt;
  assign res.lt_full = key_lt || (key_eq && (a.handle < b.handle));

endmodule

>>> rtl/top_k_latest_by_timestamp_top.sv
// channel | direction | handshake          | word
// in      | input     | in_valid / in_stall  | tkl_in_t  (mode, stamp, record_handle)
// out     | output    | out_valid / out_stall| tkl_out_t (out_stamp, out_handle, batch_end, last)
// cfg     | input     | cfg_we               | cfg_index, cfg_data
// add with room: written straight to the store; add when full: min search then replace
// flush of n records: each result takes a min search over the records still held, one memory
// read a cycle through the shared comparator
// in_stall is high whenever the sequencer is busy; a full output register that is stalled
// holds the next result back, reset is synchronous and leaves the store empty
module top_k_latest_by_timestamp_top
  import tkl_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tkl_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tkl_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int BW = (CW > CFG_W) ? CW : CFG_W;

  tkl_state_t       state_r, state_nxt;
  logic [CW-1:0]    held_r, held_nxt;
  logic [CFG_W-1:0] keep_r, keep_nxt;
  logic [CFG_W-1:0] batch_r, batch_nxt;
  tkl_entry_t       item_r, item_nxt;
  logic             drain_r, drain_nxt;
  logic [CW-1:0]    issue_r, issue_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0]    cmp_idx_r, cmp_idx_nxt;
  tkl_entry_t       best_r, best_nxt;
  logic [CW-1:0]    best_idx_r, best_idx_nxt;
  tkl_entry_t       tail_r, tail_nxt;
  logic [BW-1:0]    bcnt_r, bcnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  tkl_out_t         out_data_r, out_data_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  tkl_entry_t    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  tkl_entry_t    mem_rdata;

  tkl_entry_t cmp_a;
  tkl_entry_t cmp_b;
  tkl_cmp_t   cmp_res;

  logic [CW-1:0] keep_eff;
  tkl_entry_t    in_entry;
  logic          in_acc;
  logic          is_last;
  logic          is_end;

  tkl_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  tkl_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  assign keep_eff        = (keep_r > CAPACITY) ? CW'(CAPACITY) : CW'(keep_r);
  assign in_entry.stamp  = in_data.stamp;
  assign in_entry.handle = in_data.record_handle;
  assign in_stall        = (state_r != ST_IDLE);
  assign in_acc          = in_valid && !in_stall;
  assign is_last         = (held_r == CW'(1));
  assign is_end          = ((bcnt_r + BW'(1)) == BW'(batch_r));
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  // shared comparator: min search during scan, replace test after it
  always_comb begin
    if (state_r == ST_DECIDE) begin
      cmp_a = best_r;
      cmp_b = item_r;
    end else begin
      cmp_a = mem_rdata;
      cmp_b = best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      keep_r      <= KEEP_COUNT_RST;
      batch_r     <= BATCH_SIZE_RST;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      drain_r     <= 1'b0;
      issue_r     <= '0;
      bcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      keep_r      <= keep_nxt;
      batch_r     <= batch_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      drain_r     <= drain_nxt;
      issue_r     <= issue_nxt;
      bcnt_r      <= bcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    tail_r     <= tail_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    keep_nxt      = keep_r;
    batch_nxt     = batch_r;
    item_nxt      = item_r;
    drain_nxt     = drain_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    tail_nxt      = tail_r;
    bcnt_nxt      = bcnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = held_r[AW-1:0];
    mem_wdata     = in_entry;
    mem_re        = 1'b0;
    mem_raddr     = issue_r[AW-1:0];

    if (cfg_we) begin
      unique case (cfg_index)
        REG_KEEP_COUNT: keep_nxt  = cfg_data;
        REG_BATCH_SIZE: batch_nxt = cfg_data;
        default:        keep_nxt  = keep_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt    = in_entry;
          issue_nxt   = '0;
          cmp_vld_nxt = 1'b0;
          bcnt_nxt    = '0;
          if (in_data.mode == MODE_FLUSH) begin
            if (held_r != '0) begin
              drain_nxt = 1'b1;
              state_nxt = ST_SCAN;
            end
          end else if (keep_eff != '0) begin
            if (held_r < keep_eff) begin
              mem_we   = 1'b1;
              held_nxt = held_r + CW'(1);
            end else begin
              drain_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmp_vld_nxt = 1'b0;
        if (issue_r < held_r) begin
          mem_re      = 1'b1;
          issue_nxt   = issue_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r;
        end
        if (cmp_vld_r) begin
          tail_nxt = mem_rdata;
          if (cmp_idx_r == '0 || cmp_res.lt_full) begin
            best_nxt     = mem_rdata;
            best_idx_nxt = cmp_idx_r;
          end
          if (cmp_idx_r == held_r - CW'(1)) begin
            cmp_vld_nxt = 1'b0;
            state_nxt   = drain_r ? ST_EMIT : ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (cmp_res.lt_key) begin
          mem_we    = 1'b1;
          mem_waddr = best_idx_r[AW-1:0];
          mem_wdata = item_r;
        end
        state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_stamp  = best_r.stamp;
          out_data_nxt.out_handle = best_r.handle;
          out_data_nxt.batch_end  = is_end || is_last;
          out_data_nxt.last       = is_last;
          // fill the hole with the tail entry
          mem_we    = 1'b1;
          mem_waddr = best_idx_r[AW-1:0];
          mem_wdata = tail_r;
          held_nxt  = held_r - CW'(1);
          bcnt_nxt  = is_end ? '0 : bcnt_r + BW'(1);
          issue_nxt = '0;
          state_nxt = is_last ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/tkl_chk.sv
`include "top_k_latest_by_timestamp_top_defines.svh"

module tkl_chk
  import tkl_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input tkl_out_t out_data
);

  // stalled result word holds
  `TKL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // final word always closes a batch
  `TKL_ASSERT_NOW(a_last_end, clk, rst_n, out_valid && out_data.last, out_data.batch_end)
  // a drain in progress blocks new input
  `TKL_ASSERT_NOW(a_drain_busy, clk, rst_n, out_valid && !out_data.last, in_stall)
  // reset empties the output
  `TKL_ASSERT_NEXT_ALWAYS(a_rst_out, clk, !rst_n, !out_valid)

endmodule

bind top_k_latest_by_timestamp_top tkl_chk u_tkl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
